/* rtl/llrc_pkg.sv */
package llrc_pkg;

  // Geometry defaults and fixed field widths
  localparam int unsigned SLOT_COUNT_DEF = 64;
  localparam int unsigned LINE_CAPACITY  = 1024;
  localparam int unsigned POS_W          = $clog2(LINE_CAPACITY);
  localparam int unsigned KEPT_W         = 7;
  localparam int unsigned LINE_NUM_W     = 6;
  localparam int unsigned BYTE_W         = 8;

  localparam logic [KEPT_W-1:0] KEPT_RESET = 7'd10;
  localparam logic [BYTE_W-1:0] NEWLINE    = 8'd10;

  // Transaction kinds carried on s_tuser
  localparam logic [1:0] MODE_PUSH = 2'd0;
  localparam logic [1:0] MODE_EOS  = 2'd1;
  localparam logic [1:0] MODE_READ = 2'd2;
  localparam logic [1:0] MODE_NOP  = 2'd3;

  // Memory strobes from the control unit
  typedef struct packed {
    logic store_we;
    logic store_re;
    logic len_we;
    logic len_re;
    logic line_hit;
  } ctrl_flags_t;

  // Ring size in use: zero counts as one, capped at the slot count
  function automatic logic [KEPT_W-1:0] kept_clamp(input logic [KEPT_W-1:0] v,
                                                   input int unsigned slots);
    logic [KEPT_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = 7'd1;
    end else if (32'(v) > slots) begin
      r = KEPT_W'(slots);
    end
    return r;
  endfunction

endpackage

/* rtl/last_lines_ring_capture_core.sv */
// Path: an input goes through the read stage and the output register
// before its result is offered. Throughput: one transaction per cycle
// while m_tready keeps the output moving; each push, close or read uses
// one access of the line store and the length RAM (registered read port).
// Reset: ring pointers, held count and handshake state clear; the line store
// and length RAM are not cleared (no clearing pass); ring size resets to 10.
module last_lines_ring_capture_core #(
  parameter int unsigned SLOT_COUNT = llrc_pkg::SLOT_COUNT_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [llrc_pkg::KEPT_W-1:0] cfg_wdata,   // lines_kept
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [23:0]                 s_tdata,     // data_byte, line_number, byte_offset
  input  logic [1:0]                  s_tuser,     // mode
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [31:0]                 m_tdata,     // read_byte, line_length, lines_held
  output logic                        m_tuser      // byte_valid
);

  import llrc_pkg::*;

  localparam int unsigned SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  logic [1:0]            mode;
  logic [BYTE_W-1:0]     data_byte;
  logic [LINE_NUM_W-1:0] line_number;
  logic [POS_W-1:0]      byte_offset;
  logic                  accept;

  ctrl_flags_t           flags;
  logic [SW-1:0]         w_slot, r_slot;
  logic [POS_W-1:0]      w_pos, len_wdata;
  logic [KEPT_W-1:0]     held_out;
  logic [BYTE_W-1:0]     store_rdata;
  logic [POS_W-1:0]      len_rdata;

  logic                  p1_valid, p1_hit, p1_adv;
  logic [POS_W-1:0]      p1_offset;
  logic [KEPT_W-1:0]     p1_held;

  logic                  out_valid, out_bvalid;
  logic [BYTE_W-1:0]     out_byte;
  logic [POS_W-1:0]      out_len;
  logic [KEPT_W-1:0]     out_held;

  logic                  res_bvalid;

  // Field unpack
  assign mode        = s_tuser;
  assign data_byte   = s_tdata[7:0];
  assign line_number = s_tdata[13:8];
  assign byte_offset = s_tdata[23:14];

  // Handshake: the read stage moves on whenever the output register frees
  assign p1_adv   = !out_valid || m_tready;
  assign s_tready = !p1_valid || p1_adv;
  assign accept   = s_tvalid && s_tready;

  llrc_ctrl #(.SLOT_COUNT(SLOT_COUNT)) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .accept      (accept),
    .mode        (mode),
    .data_byte   (data_byte),
    .line_number (line_number),
    .flags       (flags),
    .w_slot      (w_slot),
    .w_pos       (w_pos),
    .len_wdata   (len_wdata),
    .r_slot      (r_slot),
    .held_out    (held_out)
  );

  // Line bytes, one row of LINE_CAPACITY per slot
  llrc_ram #(.WIDTH(BYTE_W), .DEPTH(SLOT_COUNT * LINE_CAPACITY)) u_store (
    .clk   (clk),
    .we    (flags.store_we),
    .waddr ({w_slot, w_pos}),
    .wdata (data_byte),
    .re    (flags.store_re),
    .raddr ({r_slot, byte_offset}),
    .rdata (store_rdata)
  );

  // Closed line lengths, one per slot
  llrc_ram #(.WIDTH(POS_W), .DEPTH(SLOT_COUNT)) u_len (
    .clk   (clk),
    .we    (flags.len_we),
    .waddr (w_slot),
    .wdata (len_wdata),
    .re    (flags.len_re),
    .raddr (r_slot),
    .rdata (len_rdata)
  );

  // Read stage: holds the transaction while RAM data comes back
  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
    end else if (accept) begin
      p1_valid <= 1'b1;
    end else if (p1_adv) begin
      p1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      p1_hit    <= flags.line_hit;
      p1_offset <= byte_offset;
      p1_held   <= held_out;
    end
  end

  assign res_bvalid = p1_hit && (p1_offset < len_rdata);

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (p1_valid && p1_adv) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (p1_valid && p1_adv) begin
      out_bvalid <= res_bvalid;
      out_byte   <= res_bvalid ? store_rdata : '0;
      out_len    <= p1_hit ? len_rdata : '0;
      out_held   <= p1_held;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_bvalid;
  assign m_tdata  = {7'd0, out_held, out_len, out_byte};

`ifndef SYNTH
  // A valid byte always comes from a non-empty line
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_bvalid |-> out_len != '0)
    else $error("valid byte reported with zero line length");

  // Invalid results carry a zero byte
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_bvalid |-> out_byte == '0)
    else $error("non-zero byte on an invalid result");

  // No new transaction while the read stage is stalled
  assert property (@(posedge clk) disable iff (rst)
    p1_valid && !p1_adv |-> !s_tready)
    else $error("input taken while read stage stalled");

  // A stalled read stage keeps its transaction
  assert property (@(posedge clk) disable iff (rst)
    p1_valid && !p1_adv |=> p1_valid)
    else $error("read stage transaction lost");
`endif

endmodule

/* rtl/llrc_ram.sv */
module llrc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/llrc_ctrl.sv */
module llrc_ctrl #(
  parameter int unsigned SLOT_COUNT = llrc_pkg::SLOT_COUNT_DEF,
  localparam int unsigned SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [llrc_pkg::KEPT_W-1:0]         cfg_wdata,
  input  logic                                accept,
  input  logic [1:0]                          mode,
  input  logic [llrc_pkg::BYTE_W-1:0]         data_byte,
  input  logic [llrc_pkg::LINE_NUM_W-1:0]     line_number,
  output llrc_pkg::ctrl_flags_t               flags,
  output logic [SW-1:0]                       w_slot,
  output logic [llrc_pkg::POS_W-1:0]          w_pos,
  output logic [llrc_pkg::POS_W-1:0]          len_wdata,
  output logic [SW-1:0]                       r_slot,
  output logic [llrc_pkg::KEPT_W-1:0]         held_out
);

  import llrc_pkg::*;

  logic [KEPT_W-1:0] kept;
  logic [SW-1:0]     write_slot, write_slot_next;
  logic [KEPT_W-1:0] held_count, held_count_next;
  logic [POS_W-1:0]  line_position, line_position_next;

  logic              pos_ok;
  logic [POS_W-1:0]  pos_inc;
  logic              close_line;
  logic [8:0]        slot_inc;
  logic [8:0]        rd_sum;
  logic [8:0]        rd_slot;
  logic              hit;

  // Oldest-first line number to ring slot: one wrap at most
  always_comb begin
    rd_sum  = 9'(write_slot) + 9'(kept) - 9'(held_count) + 9'(line_number);
    rd_slot = (rd_sum >= 9'(kept)) ? (rd_sum - 9'(kept)) : rd_sum;
    hit     = 7'(line_number) < held_count;
  end

  assign pos_ok   = line_position < POS_W'(LINE_CAPACITY - 1);
  assign pos_inc  = pos_ok ? (line_position + 1'b1) : line_position;
  assign slot_inc = 9'(write_slot) + 9'd1;

  assign w_slot = write_slot;
  assign w_pos  = line_position;
  assign r_slot = rd_slot[SW-1:0];

  // Per-transaction state update and memory strobes
  always_comb begin
    flags              = '0;
    close_line         = 1'b0;
    len_wdata          = line_position;
    write_slot_next    = write_slot;
    held_count_next    = held_count;
    line_position_next = line_position;
    if (accept) begin
      case (mode)
        MODE_PUSH: begin
          flags.store_we     = pos_ok;
          line_position_next = pos_inc;
          len_wdata          = pos_inc;
          close_line         = (data_byte == NEWLINE);
        end
        MODE_EOS: begin
          close_line = (line_position != '0);
        end
        MODE_READ: begin
          flags.store_re = hit;
          flags.len_re   = hit;
          flags.line_hit = hit;
        end
        default: begin
        end
      endcase
    end
    if (close_line) begin
      flags.len_we       = 1'b1;
      write_slot_next    = (slot_inc >= 9'(kept)) ? '0 : slot_inc[SW-1:0];
      held_count_next    = (held_count < kept) ? (held_count + 1'b1) : held_count;
      line_position_next = '0;
    end
  end

  assign held_out = held_count_next;

  // Ring pointers; a register write also empties the ring
  always_ff @(posedge clk) begin
    if (rst) begin
      kept          <= kept_clamp(KEPT_RESET, SLOT_COUNT);
      write_slot    <= '0;
      held_count    <= '0;
      line_position <= '0;
    end else if (cfg_we) begin
      kept          <= kept_clamp(cfg_wdata, SLOT_COUNT);
      write_slot    <= '0;
      held_count    <= '0;
      line_position <= '0;
    end else begin
      write_slot    <= write_slot_next;
      held_count    <= held_count_next;
      line_position <= line_position_next;
    end
  end

endmodule
